// ===== rtl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd_pkg: shared definitions for the button click decoder
// Widths, register indexes and reset values, event codes and the
// configuration bundle passed from the register file to the core.
// ----------------------------------------------------------------------------
package bcd_pkg;

    // Field and bus widths
    localparam int TIMER_W    = 24;
    localparam int DEB_W      = 16;
    localparam int CLICK_W    = 2;
    localparam int EVENT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int TDATA_W    = 8;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WIN  = 2'd2;

    // Configuration reset values
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 16'd100;
    localparam logic [TIMER_W-1:0] LONG_HOLD_RST = 24'd100000;
    localparam logic [TIMER_W-1:0] CLICK_WIN_RST = 24'd15000;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_TRIPLE = 2'd3;

    // Click count that ends a burst at once
    localparam logic [CLICK_W-1:0] CLICKS_TRIPLE = 2'd3;

    // Register file contents as seen by the core
    typedef struct packed {
        logic [DEB_W-1:0]   settle_ticks;
        logic [TIMER_W-1:0] long_hold_ticks;
        logic [TIMER_W-1:0] click_window_ticks;
    } cfg_t;

endpackage

// ===== rtl/bcd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bcd_cfg_regs: configuration register file
// Holds debounce, long-hold and click-window settings; write only.
// ----------------------------------------------------------------------------
module bcd_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output bcd_pkg::cfg_t                  cfg
);
    import bcd_pkg::*;

    cfg_t cfg_reg;

    // Update the addressed register; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks       <= DEBOUNCE_RST;
            cfg_reg.long_hold_ticks    <= LONG_HOLD_RST;
            cfg_reg.click_window_ticks <= CLICK_WIN_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_DEBOUNCE:  cfg_reg.settle_ticks       <= cfg_wdata[DEB_W-1:0];
                CFG_LONG_HOLD: cfg_reg.long_hold_ticks    <= cfg_wdata[TIMER_W-1:0];
                CFG_CLICK_WIN: cfg_reg.click_window_ticks <= cfg_wdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bcd_core.sv =====
// ----------------------------------------------------------------------------
// bcd_core: click state machine and result register
// Advances the debounce / click / long-hold machine once per accepted
// request and holds the resulting event code until it is taken.
// ----------------------------------------------------------------------------
module bcd_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bcd_pkg::cfg_t               cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        pin_level,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bcd_pkg::EVENT_W-1:0] event_code
);
    import bcd_pkg::*;

    typedef enum logic [2:0] {
        IDLE          = 3'd0,
        DEB_PRESS     = 3'd1,
        PRESSED       = 3'd2,
        DEB_RELEASE   = 3'd3,
        WAIT_NEXT     = 3'd4,
        LONG          = 3'd5,
        DEB_LONG_REL  = 3'd6
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [TIMER_W-1:0]  hold_reg, hold_next;
    logic [TIMER_W-1:0]  window_reg, window_next;
    logic [CLICK_W-1:0]  clicks_reg, clicks_next;
    logic                m_valid_reg, m_valid_next;
    logic [EVENT_W-1:0]  event_reg, event_next;

    logic                s_accept;
    logic [TIMER_W-1:0]  hold_inc;
    logic [CLICK_W-1:0]  clicks_inc;
    logic [TIMER_W-1:0]  debounce_ext;
    logic [EVENT_W-1:0]  ev;

    // Accept while the result slot is empty or being emptied
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign hold_inc     = (hold_reg == TIMER_MAX) ? hold_reg : hold_reg + 1'b1;
    assign clicks_inc   = clicks_reg + 1'b1;
    assign debounce_ext = {{(TIMER_W-DEB_W){1'b0}}, cfg.settle_ticks};

    // Next state for one sampled level
    always_comb begin
        mode_next   = mode_reg;
        hold_next   = hold_reg;
        window_next = window_reg;
        clicks_next = clicks_reg;
        ev          = EV_NONE;

        // Window timer runs ahead of the mode update, capped at the window
        if (clicks_reg != '0 && mode_reg != PRESSED
                && window_reg < cfg.click_window_ticks) begin
            window_next = window_reg + 1'b1;
        end

        unique case (mode_reg)
            IDLE: begin
                clicks_next = '0;
                if (pin_level) begin
                    mode_next = DEB_PRESS;
                    hold_next = '0;
                end
            end
            DEB_PRESS: begin
                if (pin_level) begin
                    hold_next = hold_inc;
                    if (hold_inc >= debounce_ext) begin
                        mode_next = PRESSED;
                        hold_next = '0;
                    end
                end else begin
                    mode_next = (clicks_reg != '0) ? WAIT_NEXT : IDLE;
                end
            end
            PRESSED: begin
                if (pin_level) begin
                    hold_next = hold_inc;
                    if (hold_inc > cfg.long_hold_ticks) begin
                        clicks_next = '0;
                        mode_next   = LONG;
                        hold_next   = '0;
                    end
                end else begin
                    mode_next = DEB_RELEASE;
                    hold_next = '0;
                end
            end
            DEB_RELEASE: begin
                if (!pin_level) begin
                    hold_next = hold_inc;
                    if (hold_inc >= debounce_ext) begin
                        clicks_next = clicks_inc;
                        if (clicks_inc == CLICKS_TRIPLE) begin
                            ev        = EV_TRIPLE;
                            mode_next = IDLE;
                        end else begin
                            window_next = '0;
                            mode_next   = WAIT_NEXT;
                        end
                    end
                end else begin
                    // Glitch during release: back to pressed; the hold count carries on from the release debounce count
                    mode_next = PRESSED;
                end
            end
            WAIT_NEXT: begin
                if (pin_level) begin
                    mode_next = DEB_PRESS;
                    hold_next = '0;
                end else if (window_next >= cfg.click_window_ticks) begin
                    ev        = clicks_reg;
                    mode_next = IDLE;
                end
            end
            LONG: begin
                if (!pin_level) begin
                    mode_next = DEB_LONG_REL;
                    hold_next = '0;
                end
            end
            DEB_LONG_REL: begin
                if (!pin_level) begin
                    hold_next = hold_inc;
                    if (hold_inc >= debounce_ext) begin
                        mode_next = IDLE;
                    end
                end else begin
                    mode_next = LONG;
                end
            end
            default: begin
                mode_next = IDLE;
            end
        endcase
    end

    // Result slot: load on accept, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        event_next   = event_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
            event_next   = ev;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= IDLE;
            hold_reg    <= '0;
            window_reg  <= '0;
            clicks_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg   <= mode_next;
                hold_reg   <= hold_next;
                window_reg <= window_next;
                clicks_reg <= clicks_next;
            end
            m_valid_reg <= m_valid_next;
        end
        event_reg <= event_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign event_code = event_reg;

endmodule

// ===== rtl/button_click_decoder.sv =====
// ----------------------------------------------------------------------------
// button_click_decoder: debounced multi-click and long-press detector
// One sampled button level in, one event code out per request.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload                         | Handshake
//  ---------+-----------+---------------------------------+------------------
//  s_       | in        | tdata[0] pin_level              | tvalid / tready
//  m_       | out       | tdata[1:0] event_code           | tvalid / tready
//  cfg_     | in        | cfg_index, cfg_wdata            | cfg_wen, no wait
//
//  One request per cycle unless stalled; its event code is registered.
//  The state update and the result register form the only stage.
//  Synchronous active-low reset restores idle and the default settings.
//  s_tready drops only while a result waits and m_tready is low.
// ----------------------------------------------------------------------------
module button_click_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration
    input  logic                           cfg_wen,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Sampled level
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcd_pkg::TDATA_W-1:0]    s_tdata,   // [0] pin_level, rest zero
    // Events
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bcd_pkg::TDATA_W-1:0]    m_tdata    // [1:0] event_code, rest zero
);
    import bcd_pkg::*;

    cfg_t               cfg;
    logic [EVENT_W-1:0] event_code;

    bcd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .pin_level  (s_tdata[0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .event_code (event_code)
    );

    // Pad the event code to a whole byte
    assign m_tdata = {{(TDATA_W-EVENT_W){1'b0}}, event_code};

endmodule

// ===== rtl/bcd_checker.sv =====
// ----------------------------------------------------------------------------
// bcd_checker: port-level checks for the button click decoder
// Watches the stream ports of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module bcd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bcd_pkg::TDATA_W-1:0] m_tdata
);
    import bcd_pkg::*;

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Empty result slot never stalls the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result slot");

    // Every accepted request yields a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    // Result without a request only if it was already waiting
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(s_tvalid && s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("result appeared without a request");

    // Padding bits stay clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TDATA_W-1:EVENT_W] == '0)
        else $error("event padding not zero");

endmodule

bind button_click_decoder bcd_checker u_bcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
